// ----- rtl/hecu_pkg.sv -----
// hamming encode/correct unit: shared types, constants and elaboration-time helpers
// used by every module of the unit; depends on nothing else
`timescale 1ns / 1ps

package hecu_pkg;

   localparam int FIELD_W           = 63;   // width of bits_in / bits_out
   localparam int LEN_W             = 6;    // data length and code length width
   localparam int SYN_W             = 6;    // syndrome width, positions up to 63
   localparam int MAX_CODE_BITS_DEF = 63;
   localparam int QUEUE_DEPTH       = 2;
   localparam logic [LEN_W-1:0] DATA_LENGTH_RESET = 6'd4;

   typedef enum logic {
      ACT_ENCODE = 1'b0,
      ACT_CHECK  = 1'b1
   } action_type;

   typedef struct packed {
      action_type         action;
      logic [FIELD_W-1:0] bits_in;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] bits_out;
      logic [LEN_W-1:0]   error_position;
      logic               error_found;
      logic               position_invalid;
   } rsp_type;

   // least r with 2^r - r >= k + 1
   function automatic logic [2:0] parity_count(input logic [LEN_W-1:0] k);
      logic [2:0] r;
      r = 3'd7;
      for (int i = 7; i >= 0; i--) begin
         if (((1 << i) - i) >= (int'(k) + 1)) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

   // largest data length whose code still fits in code_bits
   function automatic int max_data_len(input int code_bits);
      int km;
      km = 1;
      for (int k = 1; k < 64; k++) begin
         if (k + int'(parity_count(LEN_W'(k))) <= code_bits) begin
            km = k;
         end
      end
      return km;
   endfunction

   function automatic logic [LEN_W-1:0] effective_k(input logic [LEN_W-1:0] raw,
                                                    input int kmax);
      logic [LEN_W-1:0] k;
      k = raw;
      if (k == '0) begin
         k = LEN_W'(1);
      end
      if (int'(k) > kmax) begin
         k = LEN_W'(kmax);
      end
      return k;
   endfunction

   function automatic bit is_pow2(input int p);
      return (p & (p - 1)) == 0;
   endfunction

   // 1-based position of the m-th non-power-of-two position, counting upward
   function automatic int data_pos(input int m);
      int cnt;
      int pos;
      cnt = 0;
      pos = 0;
      for (int p = 3; p < 128; p++) begin
         if (!is_pow2(p)) begin
            if (cnt == m && pos == 0) begin
               pos = p;
            end
            cnt++;
         end
      end
      return pos;
   endfunction

   // positions (bit p-1 for position p) whose number has bit i set
   function automatic logic [FIELD_W-1:0] syn_mask(input int i);
      logic [FIELD_W-1:0] m;
      m = '0;
      for (int p = 1; p <= FIELD_W; p++) begin
         m[p-1] = ((p >> i) & 1) != 0;
      end
      return m;
   endfunction

endpackage

// ----- rtl/hecu_front.sv -----
// front end: data length register, data scatter, input masking and syndrome trees
// uses hecu_pkg; feeds the entry queue
`timescale 1ns / 1ps

module hecu_front #(
   parameter int MAX_CODE_BITS = hecu_pkg::MAX_CODE_BITS_DEF,
   parameter int ENTRY_W       = 1 + MAX_CODE_BITS + hecu_pkg::SYN_W + hecu_pkg::LEN_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  hecu_pkg::req_type               req_data,
   input  logic                            csr_wr_en,
   input  logic [hecu_pkg::LEN_W-1:0]      csr_wr_data,
   output logic                            q_push,
   output logic [ENTRY_W-1:0]              q_data,
   input  logic                            q_full
);
   import hecu_pkg::*;

   localparam int W    = MAX_CODE_BITS;
   localparam int KMAX = max_data_len(W);
   localparam logic [LEN_W-1:0] K_RST = effective_k(DATA_LENGTH_RESET, KMAX);

   typedef struct packed {
      action_type       action;
      logic [W-1:0]     word;
      logic [SYN_W-1:0] syn;
      logic [LEN_W-1:0] code_len;
   } entry_type;

   logic [LEN_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [KMAX-1:0]  kmask;
   logic [KMAX-1:0]  data;
   logic [W-1:0]     nmask;
   logic [W-1:0]     placed;
   logic [W-1:0]     word;
   logic [SYN_W-1:0] syn;
   entry_type        entry;

   assign k_in   = effective_k(csr_wr_data, KMAX);
   assign len_in = k_in + LEN_W'(parity_count(k_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= K_RST;
         len_ff <= K_RST + LEN_W'(parity_count(K_RST));
      end else if (csr_wr_en) begin
         k_ff   <= k_in;
         len_ff <= len_in;
      end
   end

   assign kmask = ~({KMAX{1'b1}} << k_ff);
   assign nmask = ~({W{1'b1}} << len_ff);
   assign data  = req_data.bits_in[KMAX-1:0] & kmask;

   // lowest data bit lands on position 3, then upward over non-power-of-two positions
   always_comb begin
      placed = '0;
      for (int m = 0; m < KMAX; m++) begin
         placed[data_pos(m)-1] = data[m];
      end
   end

   assign word = (req_data.action == ACT_CHECK) ? (req_data.bits_in[W-1:0] & nmask) : placed;

   always_comb begin
      logic [FIELD_W-1:0] pmask;
      pmask = '0;
      for (int i = 0; i < SYN_W; i++) begin
         pmask  = syn_mask(i);
         syn[i] = ^(word & pmask[W-1:0]);
      end
   end

   always_comb begin
      entry.action   = req_data.action;
      entry.word     = word;
      entry.syn      = syn;
      entry.code_len = len_ff;
   end

   assign full   = q_full;
   assign q_push = push && !q_full;
   assign q_data = entry;

endmodule

// ----- rtl/hecu_queue.sv -----
// small fifo between front and back ends, one beat in and one out per cycle, no push while full and no pop while empty
// uses hecu_pkg for the default depth
`timescale 1ns / 1ps

module hecu_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = hecu_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   import hecu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue pop did not lower count");

   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      do_push |=> mem_ff[$past(wr_ptr_ff)] == $past(push_data))
      else $error("queue write lost");

endmodule

// ----- rtl/hecu_back.sv -----
// back end: parity insertion or single-bit correction, result register
// uses hecu_pkg; drains the entry queue
`timescale 1ns / 1ps

module hecu_back #(
   parameter int MAX_CODE_BITS = hecu_pkg::MAX_CODE_BITS_DEF,
   parameter int ENTRY_W       = 1 + MAX_CODE_BITS + hecu_pkg::SYN_W + hecu_pkg::LEN_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  logic [ENTRY_W-1:0]  q_data,
   output logic                q_pop,
   input  logic                pop,
   output logic                empty,
   output hecu_pkg::rsp_type   rsp_data
);
   import hecu_pkg::*;

   localparam int W = MAX_CODE_BITS;

   typedef struct packed {
      action_type       action;
      logic [W-1:0]     word;
      logic [SYN_W-1:0] syn;
      logic [LEN_W-1:0] code_len;
   } entry_type;

   entry_type    entry;
   logic         check;
   logic         in_range;
   logic [W-1:0] result;
   rsp_type      rsp_ff, rsp_in;
   logic         valid_ff, valid_in;

   assign entry    = entry_type'(q_data);
   assign check    = (entry.action == ACT_CHECK);
   assign in_range = (entry.syn != '0) && (entry.syn <= entry.code_len);

   always_comb begin
      result = entry.word;
      if (check) begin
         if (in_range) begin
            for (int p = 0; p < W; p++) begin
               if (entry.syn == SYN_W'(p + 1)) begin
                  result[p] = ~result[p];
               end
            end
         end
      end else begin
         // parity bit at position 2^i takes syndrome bit i of the data-only word
         for (int i = 0; i < SYN_W; i++) begin
            if ((1 << i) <= W) begin
               result[(1 << i) - 1] = result[(1 << i) - 1] | entry.syn[i];
            end
         end
      end
   end

   always_comb begin
      rsp_in.bits_out         = FIELD_W'(result);
      rsp_in.error_position   = check ? LEN_W'(entry.syn) : '0;
      rsp_in.error_found      = check && (entry.syn != '0);
      rsp_in.position_invalid = check && (entry.syn > entry.code_len);
   end

   assign q_pop    = !q_empty && (!valid_ff || pop);
   assign valid_in = q_pop || (valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign empty    = !valid_ff;
   assign rsp_data = rsp_ff;

   a_invalid_is_error: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ff.position_invalid |-> rsp_ff.error_found)
      else $error("invalid position without error flag");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> valid_ff)
      else $error("queue beat taken but result register empty");

endmodule

// ----- rtl/hamming_encode_correct_unit.sv -----
// hamming encode / single error correction unit, configurable data length
// data path: a taken beat is written into the queue, then loaded into the result register once that is free
// throughput: one beat per cycle, both sides stall on their own through a 2-entry queue
// reset: data length returns to 4, queue and result register are emptied
// uses hecu_pkg, hecu_front, hecu_queue, hecu_back
`timescale 1ns / 1ps

module hamming_encode_correct_unit #(
   parameter int MAX_CODE_BITS = hecu_pkg::MAX_CODE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  hecu_pkg::req_type          req_data,
   input  logic                       pop,
   output logic                       empty,
   output hecu_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [hecu_pkg::LEN_W-1:0] csr_wr_data
);
   import hecu_pkg::*;

   localparam int ENTRY_W = 1 + MAX_CODE_BITS + SYN_W + LEN_W;

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   logic [ENTRY_W-1:0] q_wr_data;
   logic [ENTRY_W-1:0] q_rd_data;

   hecu_front #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .ENTRY_W       (ENTRY_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_push      (q_push),
      .q_data      (q_wr_data),
      .q_full      (q_full)
   );

   hecu_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   hecu_back #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .ENTRY_W       (ENTRY_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule
